### rtl/poi_pkg.sv
// Shared types, constants and helper functions for the planar odometry integrator.
// Used by every module under rtl but poi_checker; depends on nothing.
package poi_pkg;

    // CORDIC stage count: default and the number of angle table entries
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int CORDIC_STAGES_MAX = 24;

    // longest interval taken into account, microseconds
    localparam logic [19:0] DT_MAX = 20'd1000000;

    // round(2^60 / (2 pi * 4096 * 10^6)): rate * dt to binary angle, scaled by 2^40
    localparam logic signed [33:0] RATE_TO_BAM = 34'sd44798134;

    // CORDIC start value, Q1.30 reciprocal of the rotator gain
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // 2^6 * 10^6 = 2^12 * 15625: 2^-12 velocity times microseconds to 2^-24 metre.
    // Divide by 2^12 with a shift, then by 15625 as a multiply by ceil(2^59 / 15625)
    // and a 59-bit shift; exact for shifted numerators below 2^45.
    localparam logic [45:0] DIV_RECIP = 46'd36893488147420;
    localparam logic [63:0] DIV_HALF  = 64'd32000000;

    localparam logic [15:0] GAIN_RESET = 16'd16384;

    // configuration register indexes
    localparam logic [7:0] CFG_GAIN_FWD = 8'd0;
    localparam logic [7:0] CFG_GAIN_LAT = 8'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_ROT,
        ST_MUL_FC,
        ST_MUL_LS,
        ST_MUL_FS,
        ST_MUL_LC,
        ST_MUL_RT,
        ST_MUL_RK,
        ST_MUL_XT,
        ST_MUL_YT,
        ST_DIV_Y,
        ST_WAIT,
        ST_DONE
    } state_t;

    // operand selection of the shared multiplier
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_FC,     // scaled forward * cos
        MUL_LS,     // scaled lateral * sin
        MUL_FS,     // scaled forward * sin
        MUL_LC,     // scaled lateral * cos
        MUL_RT,     // turn rate * dt
        MUL_RK,     // (rate * dt) * angle constant
        MUL_XT,     // world x velocity * dt
        MUL_YT      // world y velocity * dt
    } mul_op_t;

    typedef struct packed {
        logic    load;
        logic    scale;
        logic    cordic_start;
        logic    cordic_quat;
        mul_op_t mul_op;
        logic    div_x_start;
        logic    div_y_start;
        logic    finish;
    } poi_cmd_t;

    typedef struct packed {
        logic cordic_busy;
        logic div_busy;
        logic out_block;
    } poi_status_t;

    // arctangent of 2^-i as a binary angle
    function automatic logic [31:0] atan_bam(input logic [4:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:    r = 32'd536870912;
            5'd1:    r = 32'd316933406;
            5'd2:    r = 32'd167458907;
            5'd3:    r = 32'd85004756;
            5'd4:    r = 32'd42667331;
            5'd5:    r = 32'd21354465;
            5'd6:    r = 32'd10679838;
            5'd7:    r = 32'd5340245;
            5'd8:    r = 32'd2670163;
            5'd9:    r = 32'd1335087;
            5'd10:   r = 32'd667544;
            5'd11:   r = 32'd333772;
            5'd12:   r = 32'd166886;
            5'd13:   r = 32'd83443;
            5'd14:   r = 32'd41722;
            5'd15:   r = 32'd20861;
            5'd16:   r = 32'd10430;
            5'd17:   r = 32'd5215;
            5'd18:   r = 32'd2608;
            5'd19:   r = 32'd1304;
            5'd20:   r = 32'd652;
            5'd21:   r = 32'd326;
            5'd22:   r = 32'd163;
            5'd23:   r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // Q1.30 to Q1.15, rounded, saturated
    function automatic logic [15:0] to_q15(input logic signed [33:0] v);
        logic signed [34:0] s;
        logic signed [19:0] r;
        s = {v[33], v} + 35'sd16384;
        r = s[34:15];
        if (r > 20'sd32767)
            return 16'h7fff;
        else if (r < -20'sd32768)
            return 16'h8000;
        return r[15:0];
    endfunction

endpackage

### rtl/poi_cordic.sv
// Iterative CORDIC rotator: one stage per cycle, sine and cosine of a binary angle.
// Depends on poi_pkg (angle table, start gain).
module poi_cordic #(
    parameter int STAGES = poi_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        angle,
    output logic               busy,
    output logic signed [33:0] cos_out,
    output logic signed [33:0] sin_out
);

    localparam int NUM = (STAGES > poi_pkg::CORDIC_STAGES_MAX) ?
                         poi_pkg::CORDIC_STAGES_MAX : STAGES;

    logic               busy_reg, busy_next;
    logic [4:0]         idx_reg, idx_next;
    logic               flip_reg, flip_next;
    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic signed [33:0] z_in;
    logic signed [33:0] x_sh, y_sh, at;

    // fold into [-90, 90] degrees, then one micro-rotation per cycle
    always_comb
    begin
        z_in      = {{2{angle[31]}}, angle};
        busy_next = busy_reg;
        idx_next  = idx_reg;
        flip_next = flip_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        x_sh      = x_reg >>> idx_reg;
        y_sh      = y_reg >>> idx_reg;
        at        = $signed({2'b00, poi_pkg::atan_bam(idx_reg)});
        if (start)
        begin
            busy_next = 1'b1;
            idx_next  = 5'd0;
            x_next    = poi_pkg::CORDIC_GAIN;
            y_next    = 34'sd0;
            if (z_in > 34'sh0_4000_0000)
            begin
                z_next    = z_in - 34'sh0_8000_0000;
                flip_next = 1'b1;
            end
            else if (z_in < -34'sh0_4000_0000)
            begin
                z_next    = z_in + 34'sh0_8000_0000;
                flip_next = 1'b1;
            end
            else
            begin
                z_next    = z_in;
                flip_next = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_next = x_reg - y_sh;
                y_next = y_reg + x_sh;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + y_sh;
                y_next = y_reg - x_sh;
                z_next = z_reg + at;
            end
            idx_next = idx_reg + 5'd1;
            if (idx_reg == 5'(NUM - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        flip_reg <= flip_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    assign busy    = busy_reg;
    assign cos_out = flip_reg ? -x_reg : x_reg;
    assign sin_out = flip_reg ? -y_reg : y_reg;

endmodule

### rtl/poi_div.sv
// Divider by 64e6 with round-half-away-from-zero: shift, then reciprocal multiply
// in four 23x23 partial products, one per cycle. Depends on poi_pkg (constants).
module poi_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] num,
    output logic               busy,
    output logic signed [32:0] quot
);

    logic        busy_reg, busy_next;
    logic [1:0]  step_reg, step_next;
    logic        neg_reg, neg_next;
    logic [44:0] t_reg, t_next;
    logic [90:0] acc_reg, acc_next;
    logic [63:0] mag;
    logic [63:0] mag_rnd;
    logic [22:0] op_a, op_b;
    logic [45:0] part;
    logic [90:0] part_sh;
    logic [31:0] q;

    // magnitude plus half divisor, drop 2^12, then accumulate t * recip
    always_comb
    begin
        mag       = num[63] ? 64'(-num) : 64'(num);
        mag_rnd   = mag + poi_pkg::DIV_HALF;
        op_a      = step_reg[1] ? {1'b0, t_reg[44:23]} : t_reg[22:0];
        op_b      = step_reg[0] ? poi_pkg::DIV_RECIP[45:23] : poi_pkg::DIV_RECIP[22:0];
        part      = op_a * op_b;
        unique case (step_reg)
            2'd0:       part_sh = {45'd0, part};
            2'd1, 2'd2: part_sh = {22'd0, part, 23'd0};
            2'd3:       part_sh = {part[44:0], 46'd0};
        endcase
        busy_next = busy_reg;
        step_next = step_reg;
        neg_next  = neg_reg;
        t_next    = t_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 2'd0;
            neg_next  = num[63];
            t_next    = mag_rnd[56:12];
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next  = acc_reg + part_sh;
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd3)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        neg_reg  <= neg_next;
        t_reg    <= t_next;
        acc_reg  <= acc_next;
    end

    assign q    = acc_reg[90:59];
    assign busy = busy_reg;
    assign quot = neg_reg ? -$signed({1'b0, q}) : $signed({1'b0, q});

endmodule

### rtl/poi_datapath.sv
// Datapath: input capture, gains, shared multiplier, CORDIC, dividers, pose state, result beat.
// Depends on poi_pkg, poi_cordic and poi_div.
module poi_datapath #(
    parameter int CORDIC_STAGES = poi_pkg::CORDIC_STAGES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  poi_pkg::poi_cmd_t   cmd,
    output poi_pkg::poi_status_t status,
    input  logic                cfg_valid,
    input  logic [7:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic signed [15:0]  speed_forward,
    input  logic signed [15:0]  speed_lateral,
    input  logic signed [15:0]  turn_rate,
    input  logic [19:0]         elapsed_time,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [47:0]  pose_x,
    output logic signed [47:0]  pose_y,
    output logic [31:0]         yaw_angle,
    output logic signed [15:0]  quat_z,
    output logic signed [15:0]  quat_w,
    output logic signed [17:0]  scaled_forward,
    output logic signed [17:0]  scaled_lateral,
    output logic signed [15:0]  rate_out
);

    logic [15:0]        gain_f_reg, gain_l_reg;
    logic signed [15:0] vf_reg, vl_reg, rate_reg;
    logic [19:0]        dt_reg;
    logic signed [17:0] sf_reg, sl_reg;
    logic signed [63:0] prod_reg, p1_reg;
    logic signed [37:0] wx_reg, wy_reg;
    logic signed [47:0] pos_x_reg, pos_y_reg;
    logic [31:0]        head_reg;
    logic               out_valid_reg;
    logic signed [47:0] o_x_reg, o_y_reg;
    logic [31:0]        o_yaw_reg;
    logic [15:0]        o_qz_reg, o_qw_reg;
    logic signed [17:0] o_sf_reg, o_sl_reg;
    logic signed [15:0] o_rate_reg;

    logic signed [32:0] sf_prod, sl_prod;
    logic signed [37:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [71:0] product;
    logic signed [63:0] wx_sum, wy_sum, h_sum;
    logic signed [33:0] c_val, s_val;
    logic               cordic_busy;
    logic [31:0]        cordic_ang;
    logic               div_x_busy, div_y_busy;
    logic signed [32:0] qx, qy;

    function automatic logic signed [47:0] sat_add(input logic signed [47:0] p,
                                                    input logic signed [32:0] d);
        logic signed [48:0] s;
        s = {p[47], p} + {{16{d[32]}}, d};
        if (s[48] != s[47])
            return s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        return s[47:0];
    endfunction

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_f_reg <= poi_pkg::GAIN_RESET;
            gain_l_reg <= poi_pkg::GAIN_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == poi_pkg::CFG_GAIN_FWD)
                gain_f_reg <= cfg_data;
            else if (cfg_index == poi_pkg::CFG_GAIN_LAT)
                gain_l_reg <= cfg_data;
        end
    end

    // gain scaling
    assign sf_prod = vf_reg * $signed({1'b0, gain_f_reg});
    assign sl_prod = vl_reg * $signed({1'b0, gain_l_reg});

    // shared multiplier operands
    always_comb
    begin
        unique case (cmd.mul_op)
            poi_pkg::MUL_FC:
            begin
                mul_a = 38'(sf_reg);
                mul_b = c_val;
            end
            poi_pkg::MUL_LS:
            begin
                mul_a = 38'(sl_reg);
                mul_b = s_val;
            end
            poi_pkg::MUL_FS:
            begin
                mul_a = 38'(sf_reg);
                mul_b = s_val;
            end
            poi_pkg::MUL_LC:
            begin
                mul_a = 38'(sl_reg);
                mul_b = c_val;
            end
            poi_pkg::MUL_RT:
            begin
                mul_a = 38'(rate_reg);
                mul_b = $signed({14'd0, dt_reg});
            end
            poi_pkg::MUL_RK:
            begin
                mul_a = prod_reg[37:0];
                mul_b = poi_pkg::RATE_TO_BAM;
            end
            poi_pkg::MUL_XT:
            begin
                mul_a = wx_reg;
                mul_b = $signed({14'd0, dt_reg});
            end
            poi_pkg::MUL_YT:
            begin
                mul_a = wy_reg;
                mul_b = $signed({14'd0, dt_reg});
            end
            default:
            begin
                mul_a = 38'sd0;
                mul_b = 34'sd0;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    // rounding of the rotated velocities and of the heading step
    assign wx_sum = p1_reg - prod_reg + 64'sd2048;
    assign wy_sum = p1_reg + prod_reg + 64'sd2048;
    assign h_sum  = prod_reg + 64'sd549755813888;

    // item capture, gain scaling and multiply sequence
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            vf_reg   <= speed_forward;
            vl_reg   <= speed_lateral;
            rate_reg <= turn_rate;
            dt_reg   <= (elapsed_time > poi_pkg::DT_MAX) ? poi_pkg::DT_MAX : elapsed_time;
        end
        if (cmd.scale)
        begin
            sf_reg <= sf_prod[31:14];
            sl_reg <= sl_prod[31:14];
        end
        if (cmd.mul_op != poi_pkg::MUL_NONE)
            prod_reg <= product[63:0];
        if (cmd.mul_op == poi_pkg::MUL_LS || cmd.mul_op == poi_pkg::MUL_LC)
            p1_reg <= prod_reg;
        if (cmd.mul_op == poi_pkg::MUL_FS)
            wx_reg <= wx_sum[49:12];
        if (cmd.mul_op == poi_pkg::MUL_RT)
            wy_reg <= wy_sum[49:12];
    end

    // p1 keeps the first product of each pair: sf*c for wx, sf*s for wy

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 32'd0;
            pos_x_reg <= 48'sd0;
            pos_y_reg <= 48'sd0;
        end
        else
        begin
            if (cmd.mul_op == poi_pkg::MUL_XT)
                head_reg <= head_reg + {{8{h_sum[63]}}, h_sum[63:40]};
            if (cmd.finish)
            begin
                pos_x_reg <= sat_add(pos_x_reg, qx);
                pos_y_reg <= sat_add(pos_y_reg, qy);
            end
        end
    end

    // shared rotator: old heading, then half of the new heading
    assign cordic_ang = cmd.cordic_quat ? {1'b0, head_reg[31:1]} : head_reg;

    poi_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.cordic_start),
        .angle   (cordic_ang),
        .busy    (cordic_busy),
        .cos_out (c_val),
        .sin_out (s_val)
    );

    poi_div u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_x_start),
        .num   (prod_reg),
        .busy  (div_x_busy),
        .quot  (qx)
    );

    poi_div u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_y_start),
        .num   (prod_reg),
        .busy  (div_y_busy),
        .quot  (qy)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            o_x_reg    <= sat_add(pos_x_reg, qx);
            o_y_reg    <= sat_add(pos_y_reg, qy);
            o_yaw_reg  <= head_reg;
            o_qz_reg   <= poi_pkg::to_q15(s_val);
            o_qw_reg   <= poi_pkg::to_q15(c_val);
            o_sf_reg   <= sf_reg;
            o_sl_reg   <= sl_reg;
            o_rate_reg <= rate_reg;
        end
    end

    assign status.cordic_busy = cordic_busy;
    assign status.div_busy    = div_x_busy | div_y_busy;
    assign status.out_block   = out_valid_reg & out_stall;

    assign out_valid      = out_valid_reg;
    assign pose_x         = o_x_reg;
    assign pose_y         = o_y_reg;
    assign yaw_angle      = o_yaw_reg;
    assign quat_z         = o_qz_reg;
    assign quat_w         = o_qw_reg;
    assign scaled_forward = o_sf_reg;
    assign scaled_lateral = o_sl_reg;
    assign rate_out       = o_rate_reg;

endmodule

### rtl/poi_ctrl.sv
// Controller: sequences capture, rotation, multiplies, divisions and the result beat.
// Depends on poi_pkg (state, command and status types).
module poi_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  poi_pkg::poi_status_t status,
    output poi_pkg::poi_cmd_t    cmd
);

    poi_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= poi_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            poi_pkg::ST_IDLE:   if (in_valid) state_next = poi_pkg::ST_SCALE;
            poi_pkg::ST_SCALE:  state_next = poi_pkg::ST_ROT;
            poi_pkg::ST_ROT:    if (!status.cordic_busy) state_next = poi_pkg::ST_MUL_FC;
            poi_pkg::ST_MUL_FC: state_next = poi_pkg::ST_MUL_LS;
            poi_pkg::ST_MUL_LS: state_next = poi_pkg::ST_MUL_FS;
            poi_pkg::ST_MUL_FS: state_next = poi_pkg::ST_MUL_LC;
            poi_pkg::ST_MUL_LC: state_next = poi_pkg::ST_MUL_RT;
            poi_pkg::ST_MUL_RT: state_next = poi_pkg::ST_MUL_RK;
            poi_pkg::ST_MUL_RK: state_next = poi_pkg::ST_MUL_XT;
            poi_pkg::ST_MUL_XT: state_next = poi_pkg::ST_MUL_YT;
            poi_pkg::ST_MUL_YT: state_next = poi_pkg::ST_DIV_Y;
            poi_pkg::ST_DIV_Y:  state_next = poi_pkg::ST_WAIT;
            poi_pkg::ST_WAIT:
                if (!status.cordic_busy && !status.div_busy)
                    state_next = poi_pkg::ST_DONE;
            poi_pkg::ST_DONE:   if (!status.out_block) state_next = poi_pkg::ST_IDLE;
            default:            state_next = poi_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != poi_pkg::ST_IDLE);
        unique case (state_reg)
            poi_pkg::ST_IDLE:   cmd.load = in_valid;
            poi_pkg::ST_SCALE:
            begin
                cmd.scale        = 1'b1;
                cmd.cordic_start = 1'b1;
            end
            poi_pkg::ST_MUL_FC: cmd.mul_op = poi_pkg::MUL_FC;
            poi_pkg::ST_MUL_LS: cmd.mul_op = poi_pkg::MUL_LS;
            poi_pkg::ST_MUL_FS: cmd.mul_op = poi_pkg::MUL_FS;
            poi_pkg::ST_MUL_LC: cmd.mul_op = poi_pkg::MUL_LC;
            poi_pkg::ST_MUL_RT: cmd.mul_op = poi_pkg::MUL_RT;
            poi_pkg::ST_MUL_RK: cmd.mul_op = poi_pkg::MUL_RK;
            poi_pkg::ST_MUL_XT: cmd.mul_op = poi_pkg::MUL_XT;
            poi_pkg::ST_MUL_YT:
            begin
                cmd.mul_op       = poi_pkg::MUL_YT;
                cmd.div_x_start  = 1'b1;
                cmd.cordic_start = 1'b1;
                cmd.cordic_quat  = 1'b1;
            end
            poi_pkg::ST_DIV_Y:  cmd.div_y_start = 1'b1;
            poi_pkg::ST_DONE:   cmd.finish = !status.out_block;
            default:            cmd = '0;
        endcase
    end

endmodule

### rtl/planar_odometry_integrator_top.sv
// Top level of the planar odometry integrator: controller plus datapath.
// Depends on poi_pkg, poi_ctrl and poi_datapath.
//
// Use: one input beat carries a body velocity sample and the microseconds
// since the previous one; each accepted beat yields exactly one result beat
// with the updated pose, the half-angle yaw quaternion and the scaled speeds.
// Input and output take a beat when valid is high and stall is low.
// Gains are written on the cfg channel (index 0 forward, 1 lateral; other
// indexes are ignored); cfg_ready is always high, write only while idle.
// From input beat to result beat, an item takes two CORDIC passes (old
// heading, then half of the new one), eight passes through the shared
// multiplier and the control steps; the reciprocal divide overlaps the
// second CORDIC pass. One item is in work at a time; the next is taken
// once the result is in the output register.
// Reset clears pose and heading to zero and the gains to 1.0.
// If the receiver stalls, the result is held and a new item may still be
// accepted; it then waits at its last step until the output register frees.
module planar_odometry_integrator_top #(
    parameter int CORDIC_STAGES = poi_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] speed_forward,
    input  logic signed [15:0] speed_lateral,
    input  logic signed [15:0] turn_rate,
    input  logic [19:0]        elapsed_time,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [47:0] pose_x,
    output logic signed [47:0] pose_y,
    output logic [31:0]        yaw_angle,
    output logic signed [15:0] quat_z,
    output logic signed [15:0] quat_w,
    output logic signed [17:0] scaled_forward,
    output logic signed [17:0] scaled_lateral,
    output logic signed [15:0] rate_out
);

    poi_pkg::poi_cmd_t    cmd;
    poi_pkg::poi_status_t status;

    assign cfg_ready = 1'b1;

    poi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    poi_datapath #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .speed_forward  (speed_forward),
        .speed_lateral  (speed_lateral),
        .turn_rate      (turn_rate),
        .elapsed_time   (elapsed_time),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pose_x         (pose_x),
        .pose_y         (pose_y),
        .yaw_angle      (yaw_angle),
        .quat_z         (quat_z),
        .quat_w         (quat_w),
        .scaled_forward (scaled_forward),
        .scaled_lateral (scaled_lateral),
        .rate_out       (rate_out)
    );

endmodule

### rtl/poi_checker.sv
// Port-level checks of the odometry integrator, bound to the top level.
// Depends on planar_odometry_integrator_top only through the bind.
module poi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [47:0] pose_x,
    input logic [31:0] yaw_angle
);

    // held result beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pose_x) && $stable(yaw_angle))
        else $error("result beat changed while stalled");

    // an accepted item keeps the block busy: the input stays stalled after the accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall ##1 in_stall)
        else $error("input taken again too early");

    // a result appears only out of an item in work
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result beat without an item in work");

    // while idle, a taken result is not followed by another
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall && out_valid && !out_stall |=> !out_valid)
        else $error("extra result beat");

endmodule

bind planar_odometry_integrator_top poi_checker u_poi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pose_x    (pose_x),
    .yaw_angle (yaw_angle)
);

### bench/planar_odometry_integrator_top_tb.sv
// Testbench for planar_odometry_integrator_top: directed table plus random beats,
// checked against a behavioral pose predictor. Depends on poi_pkg and the RTL.
`timescale 1ns / 100ps

module planar_odometry_integrator_top_tb;

    localparam int STAGES = 16;
    localparam int N_RANDOM = 1500;
    localparam int WATCHDOG = 20000;
    localparam longint POS_HI = 64'sd140737488355327;
    localparam longint POS_LO = -64'sd140737488355328;

    typedef struct packed {
        logic signed [15:0] fwd;
        logic signed [15:0] lat;
        logic signed [15:0] rate;
        logic [19:0]        dt;
    } sample_t;

    typedef struct packed {
        logic signed [47:0] px;
        logic signed [47:0] py;
        logic [31:0]        yaw;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
        logic signed [17:0] sf;
        logic signed [17:0] sl;
        logic signed [15:0] rate;
    } pose_t;

    typedef struct packed {
        sample_t s;
        logic    has_exp;
        pose_t   p;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    sample_t drv = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    pose_t got;

    // predictor state
    longint pos_x, pos_y;
    logic [31:0] head;
    logic [15:0] g_fwd, g_lat;
    pose_t pose_q[$];
    int errors = 0;
    int idle_cycles = 0;
    bit quiet = 1'b0;
    bit hold_rx = 1'b0;
    bit finished = 1'b0;

    always #6 clk = ~clk;

    planar_odometry_integrator_top #(.CORDIC_STAGES(STAGES)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .speed_forward(drv.fwd), .speed_lateral(drv.lat),
        .turn_rate(drv.rate), .elapsed_time(drv.dt),
        .out_valid(out_valid), .out_stall(out_stall),
        .pose_x(got.px), .pose_y(got.py), .yaw_angle(got.yaw),
        .quat_z(got.qz), .quat_w(got.qw),
        .scaled_forward(got.sf), .scaled_lateral(got.sl), .rate_out(got.rate)
    );

    function automatic longint atan_step(int i);
        longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
            163, 81};
        return t[i];
    endfunction

    // CORDIC rotation, Q1.30 cos and sin of a binary angle
    task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
        longint z, xs, ys;
        bit flip;
        z = longint'(signed'(ang));
        c = 652032874;
        s = 0;
        flip = 1'b0;
        if (z > (64'sd1 <<< 30))
        begin
            z -= 64'sd1 <<< 31;
            flip = 1'b1;
        end
        else if (z < -(64'sd1 <<< 30))
        begin
            z += 64'sd1 <<< 31;
            flip = 1'b1;
        end
        for (int i = 0; i < STAGES && i < 24; i++)
        begin
            xs = c >>> i;
            ys = s >>> i;
            if (z >= 0)
            begin
                c -= ys; s += xs; z -= atan_step(i);
            end
            else
            begin
                c += ys; s -= xs; z += atan_step(i);
            end
        end
        if (flip)
        begin
            c = -c; s = -s;
        end
    endtask

    function automatic longint round_div(longint n);
        if (n >= 0)
            return (n + 32000000) / 64000000;
        return -((-n + 32000000) / 64000000);
    endfunction

    function automatic longint clamp_pos(longint v);
        return v > POS_HI ? POS_HI : (v < POS_LO ? POS_LO : v);
    endfunction

    function automatic logic [15:0] q15(longint v);
        longint r;
        r = (v + 16384) >>> 15;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    // advance the pose by one sample
    task automatic integrate(input sample_t smp, output pose_t p);
        longint sf, sl, c, s, wx, wy, dt, dh, hc, hs;
        dt = smp.dt > 20'd1000000 ? 1000000 : longint'(smp.dt);
        sf = (longint'(smp.fwd) * longint'(g_fwd)) >>> 14;
        sl = (longint'(smp.lat) * longint'(g_lat)) >>> 14;
        rotate(head, c, s);
        wx = (sf * c - sl * s + 2048) >>> 12;
        wy = (sf * s + sl * c + 2048) >>> 12;
        pos_x = clamp_pos(pos_x + round_div(wx * dt));
        pos_y = clamp_pos(pos_y + round_div(wy * dt));
        dh = (longint'(smp.rate) * dt * 44798134 + (64'sd1 <<< 39)) >>> 40;
        head = head + dh[31:0];
        rotate(head >> 1, hc, hs);
        p.px = pos_x[47:0];
        p.py = pos_y[47:0];
        p.yaw = head;
        p.qz = q15(hs);
        p.qw = q15(hc);
        p.sf = sf[17:0];
        p.sl = sl[17:0];
        p.rate = smp.rate;
    endtask

    task automatic write_gain(input logic [7:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == poi_pkg::CFG_GAIN_FWD)
            g_fwd = val;
        else if (idx == poi_pkg::CFG_GAIN_LAT)
            g_lat = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // offer one beat; valid stays high across back-to-back beats
    task automatic send(input sample_t smp, input bit has_exp, input pose_t want);
        pose_t p;
        drv <= smp;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        integrate(smp, p);
        if (has_exp && p != want)
        begin
            $error("table row disagrees with predictor: %h vs %h", want, p);
            errors++;
        end
        pose_q.push_back(p);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pose_q.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    function automatic sample_t rand_sample();
        sample_t s;
        s.fwd = 16'($urandom);
        s.lat = 16'($urandom);
        s.rate = 16'($urandom);
        case ($urandom_range(0, 3))
            0: s.dt = 20'($urandom);
            1: s.dt = 20'($urandom_range(0, 20000));
            2: s.dt = 20'($urandom_range(999990, 1048575));
            default: s.dt = 20'($urandom_range(0, 1000));
        endcase
        return s;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        pose_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pose_q.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                w = pose_q.pop_front();
                if (got.px !== w.px) begin $error("pose_x exp %0d got %0d", w.px, got.px); errors++; end
                if (got.py !== w.py) begin $error("pose_y exp %0d got %0d", w.py, got.py); errors++; end
                if (got.yaw !== w.yaw) begin $error("yaw_angle exp %0d got %0d", w.yaw, got.yaw); errors++; end
                if (got.qz !== w.qz) begin $error("quat_z exp %0d got %0d", w.qz, got.qz); errors++; end
                if (got.qw !== w.qw) begin $error("quat_w exp %0d got %0d", w.qw, got.qw); errors++; end
                if (got.sf !== w.sf) begin $error("scaled_forward exp %0d got %0d", w.sf, got.sf); errors++; end
                if (got.sl !== w.sl) begin $error("scaled_lateral exp %0d got %0d", w.sl, got.sl); errors++; end
                if (got.rate !== w.rate) begin $error("rate_out exp %0d got %0d", w.rate, got.rate); errors++; end
            end
        end
    end

    // receiver stall: random bursts, a forced long hold, none when quiet
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_rx)
            begin
                out_stall <= 1'b1;
                repeat (400) @(negedge clk);
                out_stall <= 1'b0;
                hold_rx = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid || finished)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("planar_odometry_integrator_top_tb: errors");
            $finish;
        end
    end

    initial
    begin
        row_t tbl[$];
        pose_t none;
        none = '0;
        pos_x = 0; pos_y = 0; head = '0;
        g_fwd = poi_pkg::GAIN_RESET; g_lat = poi_pkg::GAIN_RESET;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // zero motion after reset: pose stays at origin, unity cosine saturates,
        // sine of zero keeps the CORDIC residue of one negative LSB
        tbl.push_back('{'{16'sd0, 16'sd0, 16'sd0, 20'd1000}, 1'b1,
            '{48'sd0, 48'sd0, 32'd0, -16'sd1, 16'sd32767, 18'sd0, 18'sd0, 16'sd0}});
        // extremes of speeds, rate, and the long interval clamp
        tbl.push_back('{'{16'sh7fff, 16'sh8000, 16'sh7fff, 20'hfffff}, 1'b0, none});
        tbl.push_back('{'{16'sh8000, 16'sh7fff, 16'sh8000, 20'd1000000}, 1'b0, none});
        tbl.push_back('{'{16'sh8000, 16'sh8000, 16'sh8000, 20'd1000001}, 1'b0, none});
        tbl.push_back('{'{16'sh7fff, 16'sh7fff, 16'sh7fff, 20'd0}, 1'b0, none});
        tbl.push_back('{'{16'sh5555, 16'shaaaa, 16'sh1234, 20'h55555}, 1'b0, none});
        tbl.push_back('{'{16'shaaaa, 16'sh5555, 16'shedcb, 20'haaaaa}, 1'b0, none});
        tbl.push_back('{'{16'sd1, -16'sd1, 16'sd4096, 20'd999999}, 1'b0, none});
        foreach (tbl[i])
            send(tbl[i].s, tbl[i].has_exp, tbl[i].p);
        drain();

        // high gains; drive position toward saturation with full-speed long steps
        write_gain(poi_pkg::CFG_GAIN_FWD, 16'hffff);
        write_gain(poi_pkg::CFG_GAIN_LAT, 16'hffff);
        write_gain(8'd7, 16'h1234);
        repeat (24)
            send('{16'sh7fff, 16'sh7fff, 16'sd0, 20'hfffff}, 1'b0, none);
        repeat (24)
            send('{16'sh8000, 16'sh8000, 16'sd0, 20'hfffff}, 1'b0, none);
        drain();

        // zero gains
        write_gain(poi_pkg::CFG_GAIN_FWD, 16'h0000);
        write_gain(poi_pkg::CFG_GAIN_LAT, 16'h0000);
        repeat (10)
            send(rand_sample(), 1'b0, none);
        drain();

        // random phases with random gains; long receiver hold in the first one
        for (int ph = 0; ph < 5; ph++)
        begin
            write_gain(poi_pkg::CFG_GAIN_FWD, 16'($urandom));
            write_gain(poi_pkg::CFG_GAIN_LAT, 16'($urandom));
            if (ph == 0)
                hold_rx = 1'b1;
            if (ph == 4)
                quiet = 1'b1;
            repeat (N_RANDOM / 5)
                send(rand_sample(), 1'b0, none);
            drain();
        end

        finished = 1'b1;
        if (errors == 0 && pose_q.size() == 0)
            $display("planar_odometry_integrator_top_tb: clean");
        else
            $display("planar_odometry_integrator_top_tb: errors");
        $finish;
    end

endmodule
